// File: rtl/bbps_pkg.sv
// Shared types and constants for the buzzer beep pattern sequencer.
// Used by bbps_step and buzzer_beep_pattern_sequencer; depends on nothing.
`default_nettype none

package bbps_pkg;

    // Beep pattern selected by a start item (codes 6 and 7 carry no timing)
    typedef enum logic [2:0] {
        PAT_OFF       = 3'd0,
        PAT_SHORT     = 3'd1,
        PAT_LONG      = 3'd2,
        PAT_DOUBLE    = 3'd3,
        PAT_DOUBLE_X2 = 3'd4,
        PAT_TRIPLE    = 3'd5
    } bbps_pattern_t;

    // Item kind carried on s_tuser
    localparam logic ACT_TICK  = 1'b0;
    localparam logic ACT_START = 1'b1;

    // Configuration register indexes
    localparam int unsigned CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SHORT_ON  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LONG_ON   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SHORT_GAP = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_GROUP_GAP = 2'd3;

    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned COUNT_W    = 4;
    localparam int unsigned PAT_W      = 3;
    localparam int unsigned S_TDATA_W  = 8;
    localparam int unsigned M_TDATA_W  = 8;

    localparam logic [CFG_DATA_W-1:0] SHORT_ON_RESET  = 16'd100;
    localparam logic [CFG_DATA_W-1:0] LONG_ON_RESET   = 16'd1000;
    localparam logic [CFG_DATA_W-1:0] SHORT_GAP_RESET = 16'd100;
    localparam logic [CFG_DATA_W-1:0] GROUP_GAP_RESET = 16'd300;

    // Phase timing registers
    typedef struct packed {
        logic [CFG_DATA_W-1:0] short_on;
        logic [CFG_DATA_W-1:0] long_on;
        logic [CFG_DATA_W-1:0] short_gap;
        logic [CFG_DATA_W-1:0] group_gap;
    } bbps_cfg_t;

    // Sequencer control state (the tick counter lives beside it, sized by TIME_WIDTH)
    typedef struct packed {
        bbps_pattern_t        pattern;
        logic                 drive;
        logic [COUNT_W-1:0]   count;
        logic                 armed;
        logic                 next_on;
    } bbps_ctrl_t;

    localparam bbps_ctrl_t CTRL_RESET = '{
        pattern: PAT_OFF,
        drive:   1'b0,
        count:   4'd0,
        armed:   1'b0,
        next_on: 1'b0
    };

endpackage

`default_nettype wire

// File: rtl/bbps_step.sv
// Next-state logic of the beep sequencer for one tick or start item.
// Depends on bbps_pkg.
`default_nettype none

module bbps_step #(
    parameter int unsigned TIME_WIDTH = 16
) (
    input  var bbps_pkg::bbps_ctrl_t      ctrl_in,
    input  var logic [TIME_WIDTH-1:0]     rem_in,
    input  var bbps_pkg::bbps_cfg_t       cfg,
    input  var logic                      action,
    input  var bbps_pkg::bbps_pattern_t   pattern,
    output bbps_pkg::bbps_ctrl_t          ctrl_out,
    output logic [TIME_WIDTH-1:0]         rem_out
);

    logic do_on;
    logic do_off;

    always_comb begin
        ctrl_out = ctrl_in;
        rem_out  = rem_in;
        do_on    = 1'b0;
        do_off   = 1'b0;

        if (action == bbps_pkg::ACT_START) begin
            // cancel whatever runs and restart the count
            ctrl_out.pattern = pattern;
            ctrl_out.drive   = 1'b0;
            ctrl_out.armed   = 1'b0;
            ctrl_out.next_on = 1'b0;
            ctrl_out.count   = '0;
            rem_out          = '0;
            do_on            = (pattern != bbps_pkg::PAT_OFF);
        end else if (ctrl_in.armed) begin
            if (rem_in <= TIME_WIDTH'(1)) begin
                rem_out = '0;
                do_on   = ctrl_in.next_on;
                do_off  = !ctrl_in.next_on;
            end else begin
                rem_out = rem_in - TIME_WIDTH'(1);
            end
        end

        if (do_on) begin
            ctrl_out.drive = 1'b1;
            case (ctrl_out.pattern)
                bbps_pkg::PAT_SHORT, bbps_pkg::PAT_DOUBLE,
                bbps_pkg::PAT_DOUBLE_X2, bbps_pkg::PAT_TRIPLE: begin
                    rem_out          = TIME_WIDTH'(cfg.short_on);
                    ctrl_out.armed   = 1'b1;
                    ctrl_out.next_on = 1'b0;
                end
                bbps_pkg::PAT_LONG: begin
                    rem_out          = TIME_WIDTH'(cfg.long_on);
                    ctrl_out.armed   = 1'b1;
                    ctrl_out.next_on = 1'b0;
                end
                default: begin
                    // no timing for this code: drop to silent and stop
                    ctrl_out.drive = 1'b0;
                    ctrl_out.armed = 1'b0;
                end
            endcase
            ctrl_out.count = ctrl_out.count + 1'b1;
        end

        if (do_off) begin
            ctrl_out.drive = 1'b0;
            ctrl_out.armed = 1'b0;
            case (ctrl_out.pattern)
                bbps_pkg::PAT_DOUBLE: begin
                    if (ctrl_out.count == 4'd1) begin
                        rem_out          = TIME_WIDTH'(cfg.short_gap);
                        ctrl_out.armed   = 1'b1;
                        ctrl_out.next_on = 1'b1;
                    end
                end
                bbps_pkg::PAT_DOUBLE_X2: begin
                    if (ctrl_out.count == 4'd1 || ctrl_out.count == 4'd5) begin
                        rem_out          = TIME_WIDTH'(cfg.short_gap);
                        ctrl_out.armed   = 1'b1;
                        ctrl_out.next_on = 1'b1;
                    end else if (ctrl_out.count == 4'd3) begin
                        rem_out          = TIME_WIDTH'(cfg.group_gap);
                        ctrl_out.armed   = 1'b1;
                        ctrl_out.next_on = 1'b1;
                    end
                end
                bbps_pkg::PAT_TRIPLE: begin
                    if (ctrl_out.count == 4'd1 || ctrl_out.count == 4'd3) begin
                        rem_out          = TIME_WIDTH'(cfg.short_gap);
                        ctrl_out.armed   = 1'b1;
                        ctrl_out.next_on = 1'b1;
                    end
                end
                default: begin
                end
            endcase
            ctrl_out.count = ctrl_out.count + 1'b1;
        end
    end

endmodule

`default_nettype wire

// File: rtl/buzzer_beep_pattern_sequencer.sv
// Top level of the buzzer beep pattern sequencer: stream ports, timing registers,
// input and result registers. Depends on bbps_pkg and bbps_step.
//
// Channel   Direction  Handshake            Carries
// s_        in         s_tvalid / s_tready  tick or start item (kind on tuser, pattern)
// m_        out        m_tvalid / m_tready  buzzer level, busy, phase count
// cfg_      in         cfg_valid/cfg_ready  timing register writes
//
// One item per cycle sustained while m_tready stays high; a result is offered on m_ once
// its item has passed the input register, then the result register, the state updating once per item.
// aresetn is synchronous, active low: clears control state and loads the default
// timings. A stalled result holds in the result register while one more item waits
// in the input register; s_tready drops only when both are full.
`default_nettype none

module buzzer_beep_pattern_sequencer #(
    parameter int unsigned TIME_WIDTH = 16
) (
    input  var logic                                     aclk,
    input  var logic                                     aresetn,
    // input items
    input  var logic                                     s_tvalid,
    output logic                                         s_tready,
    input  var logic [bbps_pkg::S_TDATA_W-1:0]           s_tdata,  // [2:0] pattern, rest zero
    input  var logic                                     s_tuser,  // [0] action (1 = start)
    // result items
    output logic                                         m_tvalid,
    input  var logic                                     m_tready,
    output logic [bbps_pkg::M_TDATA_W-1:0]               m_tdata,  // [0] buzzer_on,
                                                                   // [1] busy_res,
                                                                   // [5:2] phase_count
    // timing register writes
    input  var logic                                     cfg_valid,
    output logic                                         cfg_ready,
    input  var logic [bbps_pkg::CFG_INDEX_W-1:0]         cfg_index,
    input  var logic [bbps_pkg::CFG_DATA_W-1:0]          cfg_data
);

    // Timing registers
    bbps_pkg::bbps_cfg_t cfg_reg;

    // Input register
    logic                    in_vld_reg;
    logic                    in_vld_next;
    logic                    in_action_reg;
    bbps_pkg::bbps_pattern_t in_pattern_reg;

    // Sequencer state
    bbps_pkg::bbps_ctrl_t    ctrl_reg;
    bbps_pkg::bbps_ctrl_t    ctrl_next;
    logic [TIME_WIDTH-1:0]   rem_reg;
    logic [TIME_WIDTH-1:0]   rem_next;

    // Result register
    logic                              m_vld_reg;
    logic                              m_vld_next;
    logic [bbps_pkg::M_TDATA_W-1:0]    m_data_reg;

    logic s_accept;
    logic out_free;
    logic fire;

    // The result slot frees when empty or being taken this cycle
    assign out_free  = !m_vld_reg || m_tready;
    assign fire      = in_vld_reg && out_free;
    assign s_tready  = !in_vld_reg || out_free;
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign m_tvalid  = m_vld_reg;
    assign m_tdata   = m_data_reg;

    // Load the pending item; drop it once it moves into the result register
    always_comb begin
        if (s_accept) begin
            in_vld_next = 1'b1;
        end else if (fire) begin
            in_vld_next = 1'b0;
        end else begin
            in_vld_next = in_vld_reg;
        end
    end

    // Result slot: fill on fire, empty when taken
    always_comb begin
        if (fire) begin
            m_vld_next = 1'b1;
        end else if (m_tready) begin
            m_vld_next = 1'b0;
        end else begin
            m_vld_next = m_vld_reg;
        end
    end

    bbps_step #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_step (
        .ctrl_in  (ctrl_reg),
        .rem_in   (rem_reg),
        .cfg      (cfg_reg),
        .action   (in_action_reg),
        .pattern  (in_pattern_reg),
        .ctrl_out (ctrl_next),
        .rem_out  (rem_next)
    );

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
            m_vld_reg  <= 1'b0;
            ctrl_reg   <= bbps_pkg::CTRL_RESET;
            rem_reg    <= '0;
        end else begin
            in_vld_reg <= in_vld_next;
            m_vld_reg  <= m_vld_next;
            if (fire) begin
                ctrl_reg <= ctrl_next;
                rem_reg  <= rem_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_action_reg  <= s_tuser;
            in_pattern_reg <= bbps_pkg::bbps_pattern_t'(s_tdata[bbps_pkg::PAT_W-1:0]);
        end
        if (fire) begin
            m_data_reg <= {2'b00, ctrl_next.count, ctrl_next.armed, ctrl_next.drive};
        end
    end

    // Timing registers take writes at any time; the user must write them only while idle, the block does not enforce it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.short_on  <= bbps_pkg::SHORT_ON_RESET;
            cfg_reg.long_on   <= bbps_pkg::LONG_ON_RESET;
            cfg_reg.short_gap <= bbps_pkg::SHORT_GAP_RESET;
            cfg_reg.group_gap <= bbps_pkg::GROUP_GAP_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                bbps_pkg::CFG_SHORT_ON:  cfg_reg.short_on  <= cfg_data;
                bbps_pkg::CFG_LONG_ON:   cfg_reg.long_on   <= cfg_data;
                bbps_pkg::CFG_SHORT_GAP: cfg_reg.short_gap <= cfg_data;
                bbps_pkg::CFG_GROUP_GAP: cfg_reg.group_gap <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // No pattern goes past eight transitions
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl_reg.count <= 4'd8)
        else $error("phase count beyond eight");

    // A pending on phase is silent and a pending off phase is sounding
    a_armed_level: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl_reg.armed |-> (ctrl_reg.drive != ctrl_reg.next_on))
        else $error("armed phase disagrees with buzzer level");

    // An item moved out of the input register always lands in the result register
    a_fire_result: assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> m_vld_reg)
        else $error("processed item lost its result");

    // Start with pattern off leaves the sequencer idle with a zero count
    a_start_off: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && in_action_reg == bbps_pkg::ACT_START
              && in_pattern_reg == bbps_pkg::PAT_OFF)
        |=> (!ctrl_reg.armed && !ctrl_reg.drive && ctrl_reg.count == 4'd0))
        else $error("start off did not idle the sequencer");

endmodule

`default_nettype wire

// File: test/bbps_checker.sv
// Scoreboard for the buzzer beep pattern sequencer: watches the item, result and
// timing-write channels, predicts every result and compares it field by field.
// Depends on bbps_pkg.
module bbps_checker
    import bbps_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [S_TDATA_W-1:0]   s_tdata,
    input  logic                   s_tuser,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [M_TDATA_W-1:0]   m_tdata,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output int                     fail_count,
    output int                     pending
);

    typedef struct packed {
        logic               buzzer_on;
        logic               busy;
        logic [COUNT_W-1:0] phase_count;
    } beep_status_t;

    beep_status_t expected_status [$];
    int fails = 0;
    int outstanding = 0;

    assign fail_count = fails;
    assign pending    = outstanding;

    // timing registers as the block should hold them
    logic [CFG_DATA_W-1:0] short_on_t, long_on_t, short_gap_t, group_gap_t;

    // sequencer state
    logic [PAT_W-1:0]      tone_pattern;
    logic                  tone_level;
    logic [COUNT_W-1:0]    transitions;
    logic [CFG_DATA_W-1:0] ticks_left;
    logic                  timer_live;
    logic                  on_pending;

    task automatic report_mismatch(input string what, input int got, input int want);
        if (fails < 100)
            $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        fails++;
    endtask

    task automatic load_phase(input logic [CFG_DATA_W-1:0] len, input logic to_on);
        ticks_left = len;
        timer_live = 1'b1;
        on_pending = to_on;
    endtask

    task automatic sound_on();
        tone_level = 1'b1;
        case (tone_pattern)
            PAT_SHORT, PAT_DOUBLE, PAT_DOUBLE_X2, PAT_TRIPLE: load_phase(short_on_t, 1'b0);
            PAT_LONG: load_phase(long_on_t, 1'b0);
            default: begin
                // no timing for this code: stop at once
                tone_level = 1'b0;
                timer_live = 1'b0;
            end
        endcase
        transitions = transitions + 1'b1;
    endtask

    task automatic sound_off();
        tone_level = 1'b0;
        timer_live = 1'b0;
        case (tone_pattern)
            PAT_DOUBLE: begin
                if (transitions == 4'd1)
                    load_phase(short_gap_t, 1'b1);
            end
            PAT_DOUBLE_X2: begin
                if (transitions == 4'd1 || transitions == 4'd5)
                    load_phase(short_gap_t, 1'b1);
                else if (transitions == 4'd3)
                    load_phase(group_gap_t, 1'b1);
            end
            PAT_TRIPLE: begin
                if (transitions == 4'd1 || transitions == 4'd3)
                    load_phase(short_gap_t, 1'b1);
            end
            default: ;
        endcase
        transitions = transitions + 1'b1;
    endtask

    task automatic predict_status(input logic act, input logic [PAT_W-1:0] pat,
                                  output beep_status_t st);
        if (act == ACT_START) begin
            tone_pattern = pat;
            tone_level   = 1'b0;
            timer_live   = 1'b0;
            on_pending   = 1'b0;
            ticks_left   = '0;
            transitions  = '0;
            if (pat != PAT_OFF)
                sound_on();
        end else if (timer_live) begin
            // a zero-length phase expires on its first tick, like one
            if (ticks_left <= 1) begin
                ticks_left = '0;
                if (on_pending)
                    sound_on();
                else
                    sound_off();
            end else begin
                ticks_left = ticks_left - 1'b1;
            end
        end
        st.buzzer_on   = tone_level;
        st.busy        = timer_live;
        st.phase_count = transitions;
    endtask

    always @(posedge aclk) begin
        beep_status_t got, want;
        if (!aresetn) begin
            short_on_t   = SHORT_ON_RESET;
            long_on_t    = LONG_ON_RESET;
            short_gap_t  = SHORT_GAP_RESET;
            group_gap_t  = GROUP_GAP_RESET;
            tone_pattern = PAT_OFF;
            tone_level   = 1'b0;
            transitions  = '0;
            ticks_left   = '0;
            timer_live   = 1'b0;
            on_pending   = 1'b0;
            expected_status.delete();
        end else begin
            // results first: a result never belongs to the item taken at the same edge
            if (m_tvalid && m_tready) begin
                got.buzzer_on   = m_tdata[0];
                got.busy        = m_tdata[1];
                got.phase_count = m_tdata[5:2];
                if (expected_status.size() == 0) begin
                    report_mismatch("result with none outstanding", int'(got), -1);
                end else begin
                    want = expected_status.pop_front();
                    if (got.buzzer_on != want.buzzer_on)
                        report_mismatch("buzzer_on", got.buzzer_on, want.buzzer_on);
                    if (got.busy != want.busy)
                        report_mismatch("busy_res", got.busy, want.busy);
                    if (got.phase_count != want.phase_count)
                        report_mismatch("phase_count", got.phase_count, want.phase_count);
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_SHORT_ON:  short_on_t  = cfg_data;
                    CFG_LONG_ON:   long_on_t   = cfg_data;
                    CFG_SHORT_GAP: short_gap_t = cfg_data;
                    CFG_GROUP_GAP: group_gap_t = cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                predict_status(s_tuser, s_tdata[PAT_W-1:0], want);
                expected_status.push_back(want);
            end
        end
        outstanding <= expected_status.size();
    end

endmodule

// File: test/tb_buzzer_beep_pattern_sequencer.sv
// Testbench top for the buzzer beep pattern sequencer: clock, reset, stimulus,
// receiver stalls and the verdict. Depends on bbps_pkg, bbps_checker and the block.
module tb_buzzer_beep_pattern_sequencer;
    import bbps_pkg::*;

    // codes 6 and 7 are legal on the bus but carry no timing
    localparam logic [PAT_W-1:0] PAT_SPARE_6 = 3'd6;
    localparam logic [PAT_W-1:0] PAT_SPARE_7 = 3'd7;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int          LONG_HOLD_AT = 450;

    logic                   aclk;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;
    logic                   s_tuser   = ACT_TICK;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b1;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = CFG_SHORT_ON;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    int fail_count;
    int pending;

    // timings currently loaded, used only to size tick runs
    logic [CFG_DATA_W-1:0] timing [4] = '{SHORT_ON_RESET, LONG_ON_RESET,
                                          SHORT_GAP_RESET, GROUP_GAP_RESET};
    int          sent_items = 0;
    bit          steady = 1'b0;       // no idling on either side while set
    bit          long_hold_done = 1'b0;
    int          stall_left = 0;
    int unsigned cycles = 0;

    buzzer_beep_pattern_sequencer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    bbps_checker checker_i (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Abort a hung run
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Gap lengths: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 25);
    endfunction

    // Receiver: random stalls, plus one long hold-off so that both the result
    // register and the input register fill and s_tready drops
    always @(posedge aclk) begin
        logic rdy;
        if (!aresetn) begin
            stall_left = 0;
            rdy = 1'b1;
        end else if (!long_hold_done && sent_items >= LONG_HOLD_AT) begin
            long_hold_done = 1'b1;
            stall_left = 150;
            rdy = 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            rdy = 1'b0;
        end else if (!steady && $urandom_range(0, 3) == 0) begin
            stall_left = pick_gap();
            rdy = (stall_left == 0);
        end else begin
            rdy = 1'b1;
        end
        m_tready <= rdy;
    end

    // Offer one item after a random gap and hold it until taken; valid stays
    // high between back-to-back items
    task automatic send_item(input logic act, input logic [PAT_W-1:0] pat);
        int gap;
        gap = steady ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {{(S_TDATA_W-PAT_W){1'b0}}, pat};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sent_items++;
    endtask

    // Ticks ignore the pattern field, so fill it with noise
    task automatic send_ticks(input int n);
        repeat (n) send_item(ACT_TICK, PAT_W'($urandom_range(0, 7)));
    endtask

    // Drop valid and hold until every result is back, then let the pipeline settle
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Write all four timing registers back to back; valid drops only at the end
    task automatic write_timings(input logic [CFG_DATA_W-1:0] so, lo, sg, gg);
        logic [CFG_INDEX_W-1:0] idx [4];
        logic [CFG_DATA_W-1:0]  val [4];
        idx = '{CFG_SHORT_ON, CFG_LONG_ON, CFG_SHORT_GAP, CFG_GROUP_GAP};
        val = '{so, lo, sg, gg};
        for (int i = 0; i < 4; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
        end
        cfg_valid <= 1'b0;
        timing = val;
    endtask

    // Enough ticks to run any pattern to its end under the loaded timings, capped
    function automatic int full_span();
        int total;
        total = 2;
        foreach (timing[i])
            total += (timing[i] == 0) ? 4 : 4 * int'(timing[i]);
        return (total > 60) ? 60 : total;
    endfunction

    // Mostly a start followed by a run of ticks (often to the end, sometimes cut
    // short by the next start); the rest is single random items
    task automatic run_random(input int n);
        int done;
        int nt;
        logic [PAT_W-1:0] pat;
        done = 0;
        while (done < n) begin
            if ($urandom_range(0, 9) == 0) begin
                send_item(1'($urandom_range(0, 1)), PAT_W'($urandom_range(0, 7)));
                done++;
            end else begin
                pat = ($urandom_range(0, 99) < 85) ? PAT_W'($urandom_range(1, 5))
                                                   : PAT_W'($urandom_range(0, 7));
                send_item(ACT_START, pat);
                done++;
                nt = ($urandom_range(0, 99) < 75) ? full_span()
                                                  : $urandom_range(0, full_span());
                if (nt > n - done)
                    nt = n - done;
                send_ticks(nt);
                done += nt;
            end
        end
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset timings: a short beep runs out after its default on-time,
        // then a long beep is cut off by a fresh start
        send_item(ACT_START, PAT_SHORT);
        send_ticks(102);
        send_item(ACT_START, PAT_LONG);
        send_ticks(10);
        wait_drained();

        // Directed: tiny timings with a zero-length gap
        write_timings(16'd1, 16'd2, 16'd0, 16'd1);
        send_item(ACT_START, PAT_OFF);
        send_ticks(1);                       // tick while idle changes nothing
        send_item(ACT_START, PAT_SPARE_6);
        send_item(ACT_START, PAT_SPARE_7);
        send_ticks(1);
        send_item(ACT_START, PAT_SHORT);
        send_ticks(2);
        send_item(ACT_START, PAT_LONG);
        send_ticks(3);
        send_item(ACT_START, PAT_DOUBLE_X2);  // full run through both pairs
        send_ticks(8);
        send_item(ACT_START, PAT_TRIPLE);
        send_item(ACT_START, PAT_DOUBLE);     // start cancels the running pattern
        send_ticks(4);
        wait_drained();

        // Random phases over several timing sets; the first runs without idling
        write_timings(16'd1, 16'd1, 16'd1, 16'd1);
        steady = 1'b1;
        run_random(130);
        wait_drained();
        steady = 1'b0;

        write_timings(16'd2, 16'd3, 16'd1, 16'd4);
        run_random(130);
        wait_drained();

        write_timings(16'd0, 16'd0, 16'd0, 16'd0);
        run_random(100);
        wait_drained();

        write_timings(16'd3, 16'd5, 16'd2, 16'd6);
        run_random(130);
        wait_drained();

        // Maximum timings: phases never expire within the run
        write_timings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        run_random(40);
        wait_drained();

        write_timings(CFG_DATA_W'($urandom_range(1, 5)), CFG_DATA_W'($urandom_range(1, 5)),
                      CFG_DATA_W'($urandom_range(1, 5)), CFG_DATA_W'($urandom_range(1, 5)));
        run_random(100);
        wait_drained();

        // Catch any stray late result
        repeat (8) @(posedge aclk);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
